FILE: hdl/xmcrc_pkg.sv
// Shared constants, types and the CRC-16/XMODEM byte update for the XMODEM-CRC receiver.
package xmcrc_pkg;

  localparam int unsigned DATA_BYTES = 128;
  localparam int unsigned PACKET_LEN = DATA_BYTES + 5;
  localparam int unsigned CNT_W      = $clog2(PACKET_LEN + 1);

  localparam logic [7:0] SOH_BYTE    = 8'h01;
  localparam logic [7:0] EOT_BYTE    = 8'h04;
  localparam logic [7:0] REPORT_BYTE = 8'h76;
  localparam logic [7:0] LEAVE_BYTE  = 8'h72;

  localparam logic [8:0] SEQ_SUM     = 9'd255;

  localparam logic [CNT_W-1:0] POS_SEQ      = CNT_W'(2);
  localparam logic [CNT_W-1:0] POS_SEQ_INV  = CNT_W'(3);
  localparam logic [CNT_W-1:0] POS_DATA_END = CNT_W'(DATA_BYTES + 3);
  localparam logic [CNT_W-1:0] POS_CRC_HI   = CNT_W'(DATA_BYTES + 4);
  localparam logic [CNT_W-1:0] POS_LAST     = CNT_W'(PACKET_LEN);

  typedef enum logic [2:0] {
    RSP_ACK   = 3'd0,
    RSP_NAK   = 3'd1,
    RSP_EOT   = 3'd2,
    RSP_SUM   = 3'd3,
    RSP_LEAVE = 3'd4
  } response_e;

  typedef struct packed {
    logic        emit;
    response_e   response;
    logic [31:0] crc_sum;
    logic [7:0]  packet_number;
  } result_t;

  function automatic logic [15:0] crc_update(logic [15:0] crc_in, logic [7:0] d);
    logic [15:0] c;
    c = {crc_in[7:0], crc_in[15:8]};
    c = c ^ {8'h00, d};
    c = c ^ {12'h000, c[7:4]};
    c = c ^ {c[3:0], 12'h000};
    c = c ^ {3'b000, c[7:0], 5'b00000};
    return c;
  endfunction

endpackage

FILE: hdl/xmodem_crc_packet_receiver.sv
// Top level of the XMODEM-CRC packet receiver: input register, frame decoder, result register.
// Each received byte is captured in an input register, decoded by the frame logic and,
// where it ends a frame or is a single-byte command, its response lands in a result
// register; a new byte is taken every cycle while the result register is free or being
// drained. A packet is SOH, sequence number, its complement, 128 data bytes and a
// big-endian CRC-16/XMODEM; it is answered with ACK or NAK, and acked CRCs add into a
// wrapping 32-bit sum. With xmodem_enable cleared, bytes are consumed without effect and a
// begun frame resumes later.
module xmodem_crc_packet_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  response_o,
  output logic [31:0] crc_sum_o,
  output logic [7:0]  packet_number_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_xmodem_enable_i
);

  logic               enable_q;
  logic               in_valid_q;
  logic [7:0]         in_byte_q;
  logic               out_valid_q;
  logic [2:0]         response_q;
  logic [31:0]        crc_sum_q;
  logic [7:0]         packet_number_q;
  logic               advance;
  logic               step;
  logic               take_in;
  xmcrc_pkg::result_t res;

  assign advance     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign step        = advance && enable_q;
  assign in_stall_o  = in_valid_q && !advance;
  assign take_in     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  xmcrc_frame u_frame (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte_q),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b1;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        enable_q <= cfg_xmodem_enable_i;
      end
      if (take_in) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= step && res.emit;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_byte_q <= rx_byte_i;
    end
    if (step && res.emit) begin
      response_q      <= res.response;
      crc_sum_q       <= res.crc_sum;
      packet_number_q <= res.packet_number;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign response_o      = response_q;
  assign crc_sum_o       = crc_sum_q;
  assign packet_number_o = packet_number_q;

  // The input side only stalls while a byte is held that cannot move on.
  a_stall_needs_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked byte");

  // Single-byte command responses carry no packet number.
  a_cmd_no_number: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (response_q == xmcrc_pkg::RSP_EOT || response_q == xmcrc_pkg::RSP_SUM ||
                     response_q == xmcrc_pkg::RSP_LEAVE)) |-> (packet_number_q == 8'h00))
    else $error("command response with a packet number");

  // A disabled receiver produces no new result.
  a_disabled_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!enable_q && !out_valid_q) |=> !out_valid_q)
    else $error("result produced while reception disabled");

endmodule

FILE: hdl/xmcrc_frame.sv
// Frame decoder: packet byte counter, sequence check, running CRC and accepted CRC sum.
module xmcrc_frame (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  logic [7:0]               byte_i,
  output xmcrc_pkg::result_t       result_o
);

  logic [xmcrc_pkg::CNT_W-1:0] count_q, count_d, pos;
  logic [7:0]                  seq_q, seq_d;
  logic                        seq_ok_q, seq_ok_d;
  logic [15:0]                 crc_q, crc_d;
  logic [7:0]                  crc_hi_q, crc_hi_d;
  logic [31:0]                 sum_q, sum_d;
  logic [15:0]                 rx_crc;
  xmcrc_pkg::result_t          res;

  assign pos    = count_q + xmcrc_pkg::CNT_W'(1);
  assign rx_crc = {crc_hi_q, byte_i};

  always_comb begin
    count_d  = count_q;
    seq_d    = seq_q;
    seq_ok_d = seq_ok_q;
    crc_d    = crc_q;
    crc_hi_d = crc_hi_q;
    sum_d    = sum_q;
    res.emit          = 1'b0;
    res.response      = xmcrc_pkg::RSP_NAK;
    res.packet_number = 8'h00;
    if (count_q == '0) begin
      priority if (byte_i == xmcrc_pkg::SOH_BYTE) begin
        count_d  = xmcrc_pkg::CNT_W'(1);
        crc_d    = 16'h0000;
        seq_ok_d = 1'b0;
      end else if (byte_i == xmcrc_pkg::EOT_BYTE) begin
        res.emit     = 1'b1;
        res.response = xmcrc_pkg::RSP_EOT;
      end else if (byte_i == xmcrc_pkg::REPORT_BYTE) begin
        res.emit     = 1'b1;
        res.response = xmcrc_pkg::RSP_SUM;
      end else if (byte_i == xmcrc_pkg::LEAVE_BYTE) begin
        res.emit     = 1'b1;
        res.response = xmcrc_pkg::RSP_LEAVE;
      end else begin
        count_d = '0;
      end
    end else begin
      count_d = pos;
      priority if (pos == xmcrc_pkg::POS_SEQ) begin
        seq_d = byte_i;
      end else if (pos == xmcrc_pkg::POS_SEQ_INV) begin
        seq_ok_d = (({1'b0, seq_q} + {1'b0, byte_i}) == xmcrc_pkg::SEQ_SUM);
      end else if (pos <= xmcrc_pkg::POS_DATA_END) begin
        crc_d = xmcrc_pkg::crc_update(crc_q, byte_i);
      end else if (pos == xmcrc_pkg::POS_CRC_HI) begin
        crc_hi_d = byte_i;
      end else begin
        crc_hi_d = crc_hi_q;
      end
      if (pos >= xmcrc_pkg::POS_LAST) begin
        count_d           = '0;
        res.emit          = 1'b1;
        res.packet_number = seq_q;
        if (seq_ok_q && (rx_crc == crc_q)) begin
          sum_d        = sum_q + {16'h0000, rx_crc};
          res.response = xmcrc_pkg::RSP_ACK;
        end
      end
    end
    res.crc_sum = sum_d;
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      seq_q    <= '0;
      seq_ok_q <= 1'b0;
      crc_q    <= '0;
      crc_hi_q <= '0;
      sum_q    <= '0;
    end else if (step_i) begin
      count_q  <= count_d;
      seq_q    <= seq_d;
      seq_ok_q <= seq_ok_d;
      crc_q    <= crc_d;
      crc_hi_q <= crc_hi_d;
      sum_q    <= sum_d;
    end
  end

  // The frame counter never reaches the full packet length.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q < xmcrc_pkg::POS_LAST)
    else $error("frame byte counter out of range");

  // The accepted sum only moves on an acknowledged packet.
  a_sum_only_on_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(step_i && res.emit && res.response == xmcrc_pkg::RSP_ACK) |=> $stable(sum_q))
    else $error("accepted CRC sum changed without an ack");

  // A packet verdict is only given on the last byte of a frame.
  a_verdict_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res.emit && (res.response == xmcrc_pkg::RSP_ACK ||
                            res.response == xmcrc_pkg::RSP_NAK))
    |=> (count_q == '0))
    else $error("packet verdict without frame end");

endmodule
